// ===== rtl/pfa_pkg.sv =====
`default_nettype none

package pfa_pkg;

   localparam int FRAME_COUNT = 4096;
   localparam int FRAME_SHIFT = 12;
   localparam int RESV_FRAMES = 4;

   localparam int ADDR_W   = 30;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 1;

   localparam int FRAME_W = $clog2(FRAME_COUNT);
   localparam int FNUM_W  = ADDR_W - FRAME_SHIFT;
   localparam int BOUND_W = FNUM_W + 1;

   localparam int ROW_BITS  = (FRAME_COUNT >= 128) ? 64 : FRAME_COUNT / 2;
   localparam int ROW_COUNT = FRAME_COUNT / ROW_BITS;
   localparam int ROW_W     = $clog2(ROW_COUNT);
   localparam int BIT_W     = $clog2(ROW_BITS);

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   localparam logic [CSR_W-1:0] CSR_KERNEL_START = 1'd0;
   localparam logic [CSR_W-1:0] CSR_KERNEL_END   = 1'd1;

   typedef enum logic [MODE_W-1:0] {
      MODE_INIT  = 2'd0,
      MODE_ALLOC = 2'd1,
      MODE_FREE  = 2'd2,
      MODE_NOP   = 2'd3
   } pfa_mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_NO_FRAME     = 2'd1,
      ST_DOUBLE_FREE  = 2'd2,
      ST_OUT_OF_RANGE = 2'd3
   } pfa_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_ALLOC_RD,
      S_ALLOC_CHK,
      S_FREE_RD,
      S_FREE_CHK,
      S_DONE
   } pfa_state_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_INIT,
      WR_ALLOC,
      WR_FREE
   } pfa_wr_type;

   typedef struct packed {
      logic           capture;
      logic           row_clear;
      logic           row_step;
      logic           mem_read;
      logic           read_free_row;
      pfa_wr_type     wr_sel;
      logic           res_set;
      logic           res_alloc_addr;
      pfa_status_type res_status;
      logic           rsp_load;
   } pfa_cmd_type;

   typedef struct packed {
      pfa_mode_type req_mode;
      logic         row_last;
      logic         out_of_range;
      logic         found;
      logic         bit_used;
   } pfa_sts_type;

endpackage

`default_nettype wire

// ===== rtl/page_frame_allocator_unit.sv =====
// First-fit page frame allocator over 4096 frames of 4 KB, one used flag per frame.
// Request channel req_*: one transfer per command; mode 0 init, 1 allocate, 2 free.
// Response channel rsp_*: exactly one transfer per request, in request order.
// csr_*: write kernel_start_addr (index 0) or kernel_end_addr (index 1) while idle.
// Flags live in a 64 x 64-bit RAM with one read port.
// Init writes all 64 rows; allocate scans rows from row 0 until one has a clear
// flag; free reads only the row that holds the address, or none when the address
// is out of range; mode 3 returns status ok without touching the flags.
// One request is worked on at a time; the next is taken once the current result
// sits in the response register, so a stalled receiver holds at most one result
// while the next request is processed.
// Reset clears all flags (per-row valid bits, no clearing sweep) and both csrs.
// A stalled receiver holds rsp_tdata stable and blocks the next result and further requests.
`default_nettype none

module page_frame_allocator_unit
   import pfa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // mode[1:0], free_address[31:2]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,  // frame_address[29:0], status[31:30]
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_W-1:0]      csr_index,
   input  wire logic [ADDR_W-1:0]     csr_wdata
);

   pfa_cmd_type cmd;
   pfa_sts_type sts;

   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd),
      .sts       (sts)
   );

   pfa_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_tdata(req_tdata),
      .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule

`default_nettype wire

// ===== rtl/pfa_ram.sv =====
`default_nettype none

module pfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pfa_datapath.sv =====
`default_nettype none

module pfa_datapath
   import pfa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_W-1:0]      csr_index,
   input  wire logic [ADDR_W-1:0]     csr_wdata,
   input  wire pfa_cmd_type           cmd,
   output pfa_sts_type                sts
);

   logic [BOUND_W-1:0] lo_ff, lo_in;
   logic [BOUND_W-1:0] hi_ff, hi_in;

   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ROW_COUNT-1:0] row_valid_ff, row_valid_in;
   logic              rd_valid_ff, rd_valid_in;

   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in;
   pfa_status_type      res_status_ff, res_status_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [FNUM_W-1:0]   free_fnum;
   logic [ROW_W-1:0]    free_row;
   logic [BIT_W-1:0]    free_bit;
   logic [ROW_W-1:0]    rd_addr;
   logic [ROW_W-1:0]    wr_addr;
   logic [ROW_BITS-1:0] wr_data;
   logic                wr_en;
   logic [ROW_BITS-1:0] ram_rd_data;
   logic [ROW_BITS-1:0] rd_word;
   logic [ROW_BITS-1:0] init_word;
   logic [BIT_W-1:0]    zero_idx;
   logic [FRAME_W-1:0]  alloc_frame;

   // csr: keep kernel range as frame number bounds
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (csr_wr_en && csr_index == CSR_KERNEL_START) begin
         lo_in = BOUND_W'(csr_wdata[ADDR_W-1:FRAME_SHIFT])
               + BOUND_W'(|csr_wdata[FRAME_SHIFT-1:0]);
      end
      if (csr_wr_en && csr_index == CSR_KERNEL_END) begin
         hi_in = BOUND_W'(csr_wdata[ADDR_W-1:FRAME_SHIFT]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= '0;
         hi_ff <= '0;
      end else begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign free_fnum = addr_ff[ADDR_W-1:FRAME_SHIFT];
   assign free_row  = free_fnum[FRAME_W-1:BIT_W];
   assign free_bit  = free_fnum[BIT_W-1:0];

   // init pattern for the current row
   always_comb begin
      logic [FRAME_W-1:0] f;
      for (int j = 0; j < ROW_BITS; j++) begin
         f = {row_ff, BIT_W'(j)};
         init_word[j] = (f < FRAME_W'(RESV_FRAMES))
                     || ((BOUND_W'(f) >= lo_ff) && (BOUND_W'(f) <= hi_ff));
      end
   end

   assign rd_word = rd_valid_ff ? ram_rd_data : '0;

   // lowest clear bit, binary search
   always_comb begin
      logic [ROW_BITS-1:0] w;
      logic [ROW_BITS-1:0] low_mask;
      w = ~rd_word;
      zero_idx = '0;
      for (int k = BIT_W - 1; k >= 0; k--) begin
         low_mask = (ROW_BITS'(1) << (1 << k)) - ROW_BITS'(1);
         if ((w & low_mask) == '0) begin
            zero_idx[k] = 1'b1;
            w = w >> (1 << k);
         end
      end
   end

   assign alloc_frame = {row_ff, zero_idx};

   assign rd_addr = cmd.read_free_row ? free_row
                  : (cmd.row_step ? row_ff + ROW_W'(1) : row_ff);

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = row_ff;
      wr_data = init_word;
      case (cmd.wr_sel)
         WR_NONE: begin
            wr_en = 1'b0;
         end
         WR_INIT: begin
            wr_data = init_word;
         end
         WR_ALLOC: begin
            wr_data = rd_word | (ROW_BITS'(1) << zero_idx);
         end
         WR_FREE: begin
            wr_addr = free_row;
            wr_data = rd_word & ~(ROW_BITS'(1) << free_bit);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   pfa_ram #(
      .WIDTH(ROW_BITS),
      .DEPTH(ROW_COUNT)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (cmd.mem_read),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
      rd_valid_in = rd_valid_ff;
      if (cmd.mem_read) begin
         rd_valid_in = row_valid_ff[rd_addr];
      end
      row_in = row_ff;
      if (cmd.row_clear) begin
         row_in = '0;
      end else if (cmd.row_step) begin
         row_in = row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         row_ff       <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
         rd_valid_ff  <= rd_valid_in;
         row_ff       <= row_in;
      end
   end

   // payload registers
   always_comb begin
      addr_in       = cmd.capture ? req_tdata[MODE_W +: ADDR_W] : addr_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      if (cmd.res_set) begin
         res_status_in = cmd.res_status;
         res_addr_in   = cmd.res_alloc_addr ? ADDR_W'(alloc_frame) << FRAME_SHIFT : '0;
      end
      rsp_data_in = rsp_data_ff;
      if (cmd.rsp_load) begin
         rsp_data_in = {res_status_ff, res_addr_ff};
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tdata = rsp_data_ff;

   assign sts.req_mode     = pfa_mode_type'(req_tdata[MODE_W-1:0]);
   assign sts.row_last     = (row_ff == ROW_W'(ROW_COUNT - 1));
   assign sts.out_of_range = (BOUND_W'(free_fnum) >= BOUND_W'(FRAME_COUNT));
   assign sts.found        = ~&rd_word;
   assign sts.bit_used     = rd_word[free_bit];

endmodule

`default_nettype wire

// ===== rtl/pfa_ctrl.sv =====
`default_nettype none

module pfa_ctrl
   import pfa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output pfa_cmd_type      cmd,
   input  wire pfa_sts_type sts
);

   pfa_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.wr_sel = WR_NONE;
      cmd.res_status = ST_OK;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture   = 1'b1;
               cmd.row_clear = 1'b1;
               case (sts.req_mode)
                  MODE_INIT:  state_in = S_INIT;
                  MODE_ALLOC: state_in = S_ALLOC_RD;
                  MODE_FREE:  state_in = S_FREE_RD;
                  default: begin
                     cmd.res_set = 1'b1;
                     state_in    = S_DONE;
                  end
               endcase
            end
         end
         S_INIT: begin
            cmd.wr_sel   = WR_INIT;
            cmd.row_step = 1'b1;
            if (sts.row_last) begin
               cmd.res_set = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_ALLOC_RD: begin
            cmd.mem_read = 1'b1;
            state_in     = S_ALLOC_CHK;
         end
         S_ALLOC_CHK: begin
            if (sts.found) begin
               cmd.wr_sel         = WR_ALLOC;
               cmd.res_set        = 1'b1;
               cmd.res_alloc_addr = 1'b1;
               state_in           = S_DONE;
            end else if (sts.row_last) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_NO_FRAME;
               state_in       = S_DONE;
            end else begin
               cmd.row_step = 1'b1;
               cmd.mem_read = 1'b1;
            end
         end
         S_FREE_RD: begin
            if (sts.out_of_range) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_OUT_OF_RANGE;
               state_in       = S_DONE;
            end else begin
               cmd.mem_read      = 1'b1;
               cmd.read_free_row = 1'b1;
               state_in          = S_FREE_CHK;
            end
         end
         S_FREE_CHK: begin
            cmd.res_set = 1'b1;
            if (sts.bit_used) begin
               cmd.wr_sel = WR_FREE;
            end else begin
               cmd.res_status = ST_DOUBLE_FREE;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != S_IDLE)
      else $error("accepted request did not start work");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before transfer");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_tvalid)
      else $error("loaded result not presented");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mem_read && cmd.wr_sel != WR_NONE))
      else $error("frame table read and write in one cycle");
`endif

endmodule

`default_nettype wire
